FILE: design/mrcvc_pkg.sv
// ----------------------------------------------------------------------------
// mrcvc_pkg: shared types, constants and helpers of the range cipher
// Holds the register map, the item records passed between the front and the
// back of the block, the queue sizes and the remainder step function.
// ----------------------------------------------------------------------------
package mrcvc_pkg;

   // Default sizes of the key storage.
   localparam int NUM_RANGES_DEF = 4;
   localparam int KEY_MAX_DEF    = 16;

   // Field widths fixed by the interface.
   localparam int BYTE_W  = 8;
   localparam int RANGE_W = 2;
   localparam int KIDX_W  = 4;
   localparam int KLEN_W  = 4;

   // Configuration port.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;
   localparam int REG_LSB    = 3;

   localparam logic [REG_IDX_W-1:0] REG_CIPHER_KIND   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RANGE_COUNT   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RANGE_BOUNDS  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CAESAR_SHIFTS = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTHS   = 3'd4;

   // Request modes.
   localparam logic MODE_TRANSLATE = 1'b0;
   localparam logic MODE_LOAD      = 1'b1;

   typedef enum logic [1:0] {
      KIND_CAESAR_ENC   = 2'd0,
      KIND_CAESAR_DEC   = 2'd1,
      KIND_VIGENERE_ENC = 2'd2,
      KIND_VIGENERE_DEC = 2'd3
   } cipher_kind_type;

   // Queue between front and back, and the result queue.
   localparam int MID_DEPTH = 4;
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
   localparam int OUT_DEPTH = 8;
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   // Remainder unit: the rotated offset has a magnitude below 512 and the
   // range size is at most 256.
   localparam int SIZE_W     = 9;
   localparam int MOD_STEPS  = 3;
   localparam int MOD_STAGES = 3;
   localparam int MAG_W      = MOD_STEPS * MOD_STAGES;
   localparam int WIDE_W     = MAG_W + SIZE_W - 1;
   localparam int OFS_W      = 11;

   typedef struct packed {
      cipher_kind_type     cipher_kind;
      logic [2:0]          range_count;
      logic [63:0]         range_bounds;
      logic [31:0]         caesar_shifts;
      logic [15:0]         key_lengths;
   } csr_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               found;
      logic [RANGE_W-1:0] hit;
      logic [BYTE_W-1:0]  lo;
      logic [SIZE_W-1:0]  size;
      logic               vig;
      logic               enc;
      logic [BYTE_W-1:0]  cshift;
   } front_item_type;

   typedef struct packed {
      front_item_type     info;
      logic [BYTE_W-1:0]  key;
   } mid_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               found;
      logic [RANGE_W-1:0] hit;
      logic [BYTE_W-1:0]  lo;
      logic [SIZE_W-1:0]  size;
      logic               neg;
      logic [MAG_W-1:0]   rem;
   } stage_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               was_translated;
      logic [RANGE_W-1:0] matched_range;
   } rsp_item_type;

   // A few steps of restoring remainder: subtract size shifted left by top,
   // top-1, ... whenever it fits.
   function automatic logic [MAG_W-1:0] mod_steps(input logic [MAG_W-1:0] rem,
                                                  input logic [SIZE_W-1:0] size,
                                                  input int top);
      logic [WIDE_W-1:0] r;
      logic [WIDE_W-1:0] sh;
      r = WIDE_W'(rem);
      for (int i = 0; i < MOD_STEPS; i++) begin
         sh = WIDE_W'(size) << (top - i);
         if (r >= sh) begin
            r = r - sh;
         end
      end
      return r[MAG_W-1:0];
   endfunction

endpackage

FILE: design/multi_range_caesar_vigenere_cipher.sv
// ----------------------------------------------------------------------------
// multi_range_caesar_vigenere_cipher: multi-range Caesar / Vigenere translator
// Takes a data byte or a key byte load on push while full is low, at one
// request per clock cycle, and gives one result per data byte, none per load.
// Each result passes the front register, middle queue and remainder pipeline
// to the result queue, whose head holds it until popped. The rate is set by
// the combinational range compare and the one read port of the key table;
// the remainder unit is pipelined in three stages and never holds back the
// flow. The user must write configuration through the register port only
// while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multi_range_caesar_vigenere_cipher #(
   parameter int NUM_RANGES = mrcvc_pkg::NUM_RANGES_DEF,
   parameter int KEY_MAX    = mrcvc_pkg::KEY_MAX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_mode,
   input  logic [mrcvc_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic [mrcvc_pkg::RANGE_W-1:0]        req_range_index,
   input  logic [mrcvc_pkg::KIDX_W-1:0]         req_key_index,
   output logic                                 empty,
   input  logic                                 pop,
   output logic [mrcvc_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                                 rsp_was_translated,
   output logic [mrcvc_pkg::RANGE_W-1:0]        rsp_matched_range,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mrcvc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mrcvc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mrcvc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                 pready
);

   localparam int MID_W = $bits(mrcvc_pkg::mid_item_type);
   localparam int RSP_W = $bits(mrcvc_pkg::rsp_item_type);

   mrcvc_pkg::cipher_kind_type              cipher_kind_ff;
   logic [2:0]                              range_count_ff;
   logic [63:0]                             range_bounds_ff;
   logic [31:0]                             caesar_shifts_ff;
   logic [15:0]                             key_lengths_ff;
   logic                                    csr_write;
   logic [mrcvc_pkg::REG_IDX_W-1:0]         reg_idx;
   mrcvc_pkg::csr_type                      csr;

   logic                                    mid_push;
   logic                                    mid_pop;
   logic                                    mid_empty;
   logic [mrcvc_pkg::MID_CNT_W-1:0]         mid_count;
   mrcvc_pkg::mid_item_type                 mid_in_item;
   logic [MID_W-1:0]                        mid_out_bits;
   logic                                    rsp_push;
   mrcvc_pkg::rsp_item_type                 rsp_in_item;
   logic [RSP_W-1:0]                        rsp_out_bits;
   mrcvc_pkg::rsp_item_type                 rsp_head;
   logic [mrcvc_pkg::OUT_CNT_W-1:0]         out_count;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = paddr[mrcvc_pkg::CSR_ADDR_W-1:mrcvc_pkg::REG_LSB];

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_kind_ff   <= mrcvc_pkg::KIND_CAESAR_ENC;
         range_count_ff   <= '0;
         range_bounds_ff  <= '0;
         caesar_shifts_ff <= '0;
         key_lengths_ff   <= '0;
      end else if (csr_write) begin
         unique case (reg_idx)
            mrcvc_pkg::REG_CIPHER_KIND: begin
               cipher_kind_ff <= mrcvc_pkg::cipher_kind_type'(pwdata[1:0]);
            end
            mrcvc_pkg::REG_RANGE_COUNT:   range_count_ff   <= pwdata[2:0];
            mrcvc_pkg::REG_RANGE_BOUNDS:  range_bounds_ff  <= pwdata;
            mrcvc_pkg::REG_CAESAR_SHIFTS: caesar_shifts_ff <= pwdata[31:0];
            mrcvc_pkg::REG_KEY_LENGTHS:   key_lengths_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         mrcvc_pkg::REG_CIPHER_KIND:   prdata = 64'(cipher_kind_ff);
         mrcvc_pkg::REG_RANGE_COUNT:   prdata = 64'(range_count_ff);
         mrcvc_pkg::REG_RANGE_BOUNDS:  prdata = range_bounds_ff;
         mrcvc_pkg::REG_CAESAR_SHIFTS: prdata = 64'(caesar_shifts_ff);
         mrcvc_pkg::REG_KEY_LENGTHS:   prdata = 64'(key_lengths_ff);
         default:                      prdata = '0;
      endcase
   end

   always_comb begin
      csr.cipher_kind   = cipher_kind_ff;
      csr.range_count   = range_count_ff;
      csr.range_bounds  = range_bounds_ff;
      csr.caesar_shifts = caesar_shifts_ff;
      csr.key_lengths   = key_lengths_ff;
   end

   mrcvc_front #(
      .NUM_RANGES (NUM_RANGES),
      .KEY_MAX    (KEY_MAX)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_mode        (req_mode),
      .req_data_byte   (req_data_byte),
      .req_range_index (req_range_index),
      .req_key_index   (req_key_index),
      .csr             (csr),
      .mid_count       (mid_count),
      .mid_push        (mid_push),
      .mid_item        (mid_in_item)
   );

   mrcvc_fifo #(
      .WIDTH (MID_W),
      .DEPTH (mrcvc_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_item),
      .pop       (mid_pop),
      .pop_data  (mid_out_bits),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   mrcvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mrcvc_pkg::mid_item_type'(mid_out_bits)),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_in_item)
   );

   mrcvc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (mrcvc_pkg::OUT_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_item),
      .pop       (pop && !empty),
      .pop_data  (rsp_out_bits),
      .empty     (empty),
      .count     (out_count)
   );

   assign rsp_head           = mrcvc_pkg::rsp_item_type'(rsp_out_bits);
   assign rsp_out_byte       = rsp_head.out_byte;
   assign rsp_was_translated = rsp_head.was_translated;
   assign rsp_matched_range  = rsp_head.matched_range;

endmodule

FILE: design/mrcvc_ram.sv
// ----------------------------------------------------------------------------
// mrcvc_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mrcvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mrcvc_fifo.sv
// ----------------------------------------------------------------------------
// mrcvc_fifo: small register queue
// Holds up to DEPTH entries; the oldest entry is shown on pop_data.
// ----------------------------------------------------------------------------
module mrcvc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic [WIDTH-1:0]                 push_data,
   input  logic                             pop,
   output logic [WIDTH-1:0]                 pop_data,
   output logic                             empty,
   output logic [$clog2(DEPTH + 1)-1:0]     count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

FILE: design/mrcvc_front.sv
// ----------------------------------------------------------------------------
// mrcvc_front: request intake and range classification
// Matches each byte against the ranges, keeps the key positions, owns the
// key table and hands classified bytes with their key byte to the back.
// ----------------------------------------------------------------------------
module mrcvc_front #(
   parameter int NUM_RANGES = mrcvc_pkg::NUM_RANGES_DEF,
   parameter int KEY_MAX    = mrcvc_pkg::KEY_MAX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_mode,
   input  logic [mrcvc_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic [mrcvc_pkg::RANGE_W-1:0]        req_range_index,
   input  logic [mrcvc_pkg::KIDX_W-1:0]         req_key_index,
   input  mrcvc_pkg::csr_type                   csr,
   input  logic [mrcvc_pkg::MID_CNT_W-1:0]      mid_count,
   output logic                                 mid_push,
   output mrcvc_pkg::mid_item_type              mid_item
);

   localparam int DEPTH = NUM_RANGES * KEY_MAX;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int CNT_W = mrcvc_pkg::MID_CNT_W + 1;

   logic                              accept;
   logic                              is_load;
   logic                              load_ok;
   logic                              found;
   logic [mrcvc_pkg::RANGE_W-1:0]     hit;
   logic [mrcvc_pkg::BYTE_W-1:0]      sel_lo;
   logic [mrcvc_pkg::BYTE_W-1:0]      sel_hi;
   logic [mrcvc_pkg::BYTE_W-1:0]      sel_shift;
   logic [POS_W-1:0]                  sel_pos;
   logic                              enc;
   logic                              vig;
   logic [AW-1:0]                     wr_addr;
   logic [AW-1:0]                     rd_addr;
   logic [mrcvc_pkg::BYTE_W-1:0]      key_byte;
   logic [POS_W-1:0]                  last_pos [NUM_RANGES];
   logic [POS_W-1:0]                  pos_ff [NUM_RANGES];
   logic [POS_W-1:0]                  pos_in [NUM_RANGES];
   logic                              f_vld_ff;
   mrcvc_pkg::front_item_type         f_item_ff, f_item_in;

   // Room is reserved for the item still waiting on its key read.
   assign full    = ({1'b0, mid_count} + CNT_W'(f_vld_ff)) >= CNT_W'(mrcvc_pkg::MID_DEPTH);
   assign accept  = push && !full;
   assign is_load = (req_mode == mrcvc_pkg::MODE_LOAD);
   assign load_ok = (32'(req_range_index) < NUM_RANGES) && (32'(req_key_index) < KEY_MAX);

   // Scan from the top so that the lowest matching range wins.
   always_comb begin
      found     = 1'b0;
      hit       = '0;
      sel_lo    = '0;
      sel_hi    = '0;
      sel_shift = '0;
      sel_pos   = '0;
      for (int r = NUM_RANGES - 1; r >= 0; r--) begin
         if ((32'(r) < 32'(csr.range_count)) &&
             (req_data_byte >= csr.range_bounds[16*r +: 8]) &&
             (req_data_byte <= csr.range_bounds[16*r+8 +: 8])) begin
            found     = 1'b1;
            hit       = mrcvc_pkg::RANGE_W'(r);
            sel_lo    = csr.range_bounds[16*r +: 8];
            sel_hi    = csr.range_bounds[16*r+8 +: 8];
            sel_shift = csr.caesar_shifts[8*r +: 8];
            sel_pos   = pos_ff[r];
         end
      end
   end

   always_comb begin
      case (csr.cipher_kind) inside
         mrcvc_pkg::KIND_CAESAR_ENC, mrcvc_pkg::KIND_VIGENERE_ENC: enc = 1'b1;
         default:                                                  enc = 1'b0;
      endcase
      case (csr.cipher_kind) inside
         mrcvc_pkg::KIND_VIGENERE_ENC, mrcvc_pkg::KIND_VIGENERE_DEC: vig = 1'b1;
         default:                                                    vig = 1'b0;
      endcase
   end

   always_comb begin
      f_item_in.data_byte = req_data_byte;
      f_item_in.found     = found;
      f_item_in.hit       = hit;
      f_item_in.lo        = sel_lo;
      f_item_in.size      = ({1'b0, sel_hi} - {1'b0, sel_lo}) + 9'd1;
      f_item_in.vig       = vig;
      f_item_in.enc       = enc;
      f_item_in.cshift    = sel_shift;
   end

   // All positions advance together on every translated byte, each wrapping
   // at its own key length; any key load restarts them.
   always_comb begin
      for (int r = 0; r < NUM_RANGES; r++) begin
         last_pos[r] = (5'(csr.key_lengths[4*r +: 4]) > 5'(KEY_MAX - 1)) ?
                       POS_W'(KEY_MAX - 1) : POS_W'(csr.key_lengths[4*r +: 4]);
         pos_in[r] = pos_ff[r];
         if (accept && is_load) begin
            pos_in[r] = '0;
         end else if (accept && found) begin
            pos_in[r] = (pos_ff[r] >= last_pos[r]) ? '0 : POS_W'(pos_ff[r] + 1'b1);
         end
      end
   end

   assign wr_addr = AW'(req_range_index) * AW'(KEY_MAX) + AW'(req_key_index);
   assign rd_addr = AW'(hit) * AW'(KEY_MAX) + AW'(sel_pos);

   mrcvc_ram #(
      .WIDTH (mrcvc_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (accept && is_load && load_ok),
      .wr_addr (wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (accept && !is_load),
      .rd_addr (rd_addr),
      .rd_data (key_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
         for (int r = 0; r < NUM_RANGES; r++) begin
            pos_ff[r] <= '0;
         end
      end else begin
         f_vld_ff <= accept && !is_load;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_item_ff <= f_item_in;
      end
   end

   assign mid_push      = f_vld_ff;
   assign mid_item.info = f_item_ff;
   assign mid_item.key  = key_byte;

endmodule

FILE: design/mrcvc_back.sv
// ----------------------------------------------------------------------------
// mrcvc_back: rotation within the matched range
// Forms the signed offset, reduces it modulo the range size in a short
// pipeline and writes finished results into the result queue.
// ----------------------------------------------------------------------------
module mrcvc_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 mid_empty,
   input  mrcvc_pkg::mid_item_type              mid_item,
   output logic                                 mid_pop,
   input  logic [mrcvc_pkg::OUT_CNT_W-1:0]      out_count,
   output logic                                 rsp_push,
   output mrcvc_pkg::rsp_item_type              rsp_item
);

   localparam int NST   = mrcvc_pkg::MOD_STAGES;
   localparam int OC_W  = mrcvc_pkg::OUT_CNT_W + 1;
   localparam int OFS_W = mrcvc_pkg::OFS_W;

   logic [NST:0]                    vld_ff;
   mrcvc_pkg::stage_type            stg_ff [NST+1];
   mrcvc_pkg::stage_type            stg_in [NST+1];
   logic [OC_W-1:0]                 inflight;
   logic                            credit;
   logic [mrcvc_pkg::BYTE_W-1:0]    ofs;
   logic [OFS_W-1:0]                shift;
   logic [OFS_W-1:0]                t;
   logic [OFS_W-1:0]                t_abs;
   logic [mrcvc_pkg::SIZE_W-1:0]    m;

   // An item is taken only when the result queue is sure to have room for
   // it and for everything already in the pipeline.
   always_comb begin
      inflight = '0;
      for (int k = 0; k <= NST; k++) begin
         inflight = inflight + OC_W'(vld_ff[k]);
      end
   end

   assign credit  = (OC_W'(out_count) + inflight) < OC_W'(mrcvc_pkg::OUT_DEPTH);
   assign mid_pop = !mid_empty && credit;

   always_comb begin
      ofs   = mid_item.info.data_byte - mid_item.info.lo;
      shift = mid_item.info.vig ?
              (OFS_W'(mid_item.key) - OFS_W'(mid_item.info.lo)) :
              OFS_W'(mid_item.info.cshift);
      t     = mid_item.info.enc ? (OFS_W'(ofs) + shift) : (OFS_W'(ofs) - shift);
      t_abs = t[OFS_W-1] ? (~t + 1'b1) : t;

      stg_in[0].data_byte = mid_item.info.data_byte;
      stg_in[0].found     = mid_item.info.found;
      stg_in[0].hit       = mid_item.info.hit;
      stg_in[0].lo        = mid_item.info.lo;
      stg_in[0].size      = mid_item.info.size;
      stg_in[0].neg       = t[OFS_W-1];
      stg_in[0].rem       = t_abs[mrcvc_pkg::MAG_W-1:0];

      for (int k = 1; k <= NST; k++) begin
         stg_in[k]     = stg_ff[k-1];
         stg_in[k].rem = mrcvc_pkg::mod_steps(stg_ff[k-1].rem, stg_ff[k-1].size,
                            mrcvc_pkg::MAG_W - 1 - (k - 1) * mrcvc_pkg::MOD_STEPS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NST-1:0], mid_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         stg_ff[0] <= stg_in[0];
      end
      for (int k = 1; k <= NST; k++) begin
         stg_ff[k] <= stg_in[k];
      end
   end

   // A negative offset with a nonzero remainder folds back from the top.
   always_comb begin
      m = (stg_ff[NST].neg && (stg_ff[NST].rem != '0)) ?
          (stg_ff[NST].size - mrcvc_pkg::SIZE_W'(stg_ff[NST].rem)) :
          mrcvc_pkg::SIZE_W'(stg_ff[NST].rem);
      rsp_item.out_byte       = stg_ff[NST].found ?
                                (stg_ff[NST].lo + m[mrcvc_pkg::BYTE_W-1:0]) :
                                stg_ff[NST].data_byte;
      rsp_item.was_translated = stg_ff[NST].found;
      rsp_item.matched_range  = stg_ff[NST].hit;
   end

   assign rsp_push = vld_ff[NST];

endmodule

FILE: design/mrcvc_checker.sv
// ----------------------------------------------------------------------------
// mrcvc_checker: port-level checks of the range cipher
// Watches the request and result queue ports and is bound to the top level.
// ----------------------------------------------------------------------------
module mrcvc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 full,
   input logic                                 empty,
   input logic                                 pop,
   input logic [mrcvc_pkg::BYTE_W-1:0]         rsp_out_byte,
   input logic                                 rsp_was_translated,
   input logic [mrcvc_pkg::RANGE_W-1:0]        rsp_matched_range
);

   // After reset nothing is waiting and requests are taken.
   a_clean_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (empty && !full))
      else $error("queues not clear after reset");

   // A byte outside every range reports range zero.
   a_untranslated_range: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_was_translated) |-> (rsp_matched_range == '0))
      else $error("untranslated result carries a range index");

   a_result_stays: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("waiting result vanished");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> ($stable(rsp_out_byte) && $stable(rsp_was_translated) &&
                            $stable(rsp_matched_range)))
      else $error("waiting result changed");

endmodule

bind multi_range_caesar_vigenere_cipher mrcvc_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .full               (full),
   .empty              (empty),
   .pop                (pop),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_was_translated (rsp_was_translated),
   .rsp_matched_range  (rsp_matched_range)
);
